// File: design/sbem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbem_pkg
// Shared types, register map, operation codes and widths for the spectral
// band energy meter.
// ----------------------------------------------------------------------------
package sbem_pkg;

    localparam int BIN_W   = 11;
    localparam int MAG_W   = 24;
    localparam int LVLC_W  = 24;
    localparam int SUM_W   = 59;
    localparam int RAW_W   = 30;
    localparam int IDX_W   = 10;
    localparam int FREQ_W  = 16;
    localparam int KIND_W  = 3;
    localparam int LOG_W   = 37;
    localparam int NUM_W   = 72;
    localparam int DVS_W   = 64;
    localparam int PADDR_W = 5;

    localparam int DEF_FFT_POINTS     = 2048;
    localparam int DEF_SAMPLE_RATE_HZ = 8000;
    localparam int DEF_MAG_BITS       = 24;

    // Register indexes
    localparam logic [2:0] REG_EDGE_ZERO  = 3'd0;
    localparam logic [2:0] REG_EDGE_ONE   = 3'd1;
    localparam logic [2:0] REG_EDGE_TWO   = 3'd2;
    localparam logic [2:0] REG_EDGE_THREE = 3'd3;
    localparam logic [2:0] REG_EDGE_FOUR  = 3'd4;
    localparam logic [2:0] REG_REF_TOP    = 3'd5;
    localparam logic [2:0] REG_IDX_FLOOR  = 3'd6;
    localparam logic [2:0] REG_IDX_CEIL   = 3'd7;

    localparam logic [BIN_W-1:0]  RST_EDGE_ZERO  = 11'd10;
    localparam logic [BIN_W-1:0]  RST_EDGE_ONE   = 11'd16;
    localparam logic [BIN_W-1:0]  RST_EDGE_TWO   = 11'd26;
    localparam logic [BIN_W-1:0]  RST_EDGE_THREE = 11'd41;
    localparam logic [BIN_W-1:0]  RST_EDGE_FOUR  = 11'd64;
    localparam logic [BIN_W-1:0]  RST_REF_TOP    = 11'd256;
    localparam logic [LVLC_W-1:0] RST_IDX_FLOOR  = 24'd100;
    localparam logic [LVLC_W-1:0] RST_IDX_CEIL   = 24'd50000;

    // Shared unit operations
    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_SQRT = 2'd1;
    localparam logic [1:0] OP_LOG  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_BAND_ZERO = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOW       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SHARE     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PEAK      = 3'd6;

    localparam logic [IDX_W-1:0]  IDX_FULL = 10'd1000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 16'hFFFF;

    typedef struct packed {
        logic [4:0][BIN_W-1:0] edge_bin;
        logic [BIN_W-1:0]      ref_top;
        logic [LVLC_W-1:0]     idx_floor;
        logic [LVLC_W-1:0]     idx_ceil;
    } cfg_t;

    typedef struct packed {
        logic [3:0][SUM_W-1:0] band_sum;
        logic [SUM_W-1:0]      low_sum;
        logic [SUM_W-1:0]      ref_sum;
        logic [MAG_W-1:0]      peak_mag;
        logic [BIN_W-1:0]      peak_bin;
    } frame_t;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [NUM_W-1:0] a;
        logic [DVS_W-1:0] b;
    } alu_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DVS_W-1:0] result;
    } alu_sts_t;

endpackage
`default_nettype wire

// File: design/sbem_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbem_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sbem_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sbem_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output sbem_pkg::cfg_t                     cfg
);
    import sbem_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] sel;
    logic       wr_en;

    assign sel   = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_bin[0] <= RST_EDGE_ZERO;
            cfg_reg.edge_bin[1] <= RST_EDGE_ONE;
            cfg_reg.edge_bin[2] <= RST_EDGE_TWO;
            cfg_reg.edge_bin[3] <= RST_EDGE_THREE;
            cfg_reg.edge_bin[4] <= RST_EDGE_FOUR;
            cfg_reg.ref_top     <= RST_REF_TOP;
            cfg_reg.idx_floor   <= RST_IDX_FLOOR;
            cfg_reg.idx_ceil    <= RST_IDX_CEIL;
        end else if (wr_en) begin
            case (sel)
                REG_EDGE_ZERO:  cfg_reg.edge_bin[0] <= pwdata[BIN_W-1:0];
                REG_EDGE_ONE:   cfg_reg.edge_bin[1] <= pwdata[BIN_W-1:0];
                REG_EDGE_TWO:   cfg_reg.edge_bin[2] <= pwdata[BIN_W-1:0];
                REG_EDGE_THREE: cfg_reg.edge_bin[3] <= pwdata[BIN_W-1:0];
                REG_EDGE_FOUR:  cfg_reg.edge_bin[4] <= pwdata[BIN_W-1:0];
                REG_REF_TOP:    cfg_reg.ref_top     <= pwdata[BIN_W-1:0];
                REG_IDX_FLOOR:  cfg_reg.idx_floor   <= pwdata[LVLC_W-1:0];
                REG_IDX_CEIL:   cfg_reg.idx_ceil    <= pwdata[LVLC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_EDGE_ZERO:  prdata = {21'd0, cfg_reg.edge_bin[0]};
            REG_EDGE_ONE:   prdata = {21'd0, cfg_reg.edge_bin[1]};
            REG_EDGE_TWO:   prdata = {21'd0, cfg_reg.edge_bin[2]};
            REG_EDGE_THREE: prdata = {21'd0, cfg_reg.edge_bin[3]};
            REG_EDGE_FOUR:  prdata = {21'd0, cfg_reg.edge_bin[4]};
            REG_REF_TOP:    prdata = {21'd0, cfg_reg.ref_top};
            REG_IDX_FLOOR:  prdata = {8'd0, cfg_reg.idx_floor};
            REG_IDX_CEIL:   prdata = {8'd0, cfg_reg.idx_ceil};
            default:        prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: design/sbem_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbem_accum
// Per-bin front end: square the magnitude, then add it into the band, low and
// reference sums and track the low-band peak.
// ----------------------------------------------------------------------------
module sbem_accum #(
    parameter int FFT_POINTS = sbem_pkg::DEF_FFT_POINTS,
    parameter int MAG_BITS   = sbem_pkg::DEF_MAG_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sbem_pkg::cfg_t              cfg,
    input  wire logic                        in_take,
    input  wire logic [sbem_pkg::BIN_W-1:0]  in_bin,
    input  wire logic [sbem_pkg::MAG_W-1:0]  in_mag,
    input  wire logic                        in_end,
    input  wire logic                        frame_clear,
    output logic                             busy,
    output logic                             frame_go,
    output sbem_pkg::frame_t                 frame
);
    import sbem_pkg::*;

    localparam logic [MAG_W-1:0]  MagMax = MAG_W'((64'd1 << MAG_BITS) - 64'd1);
    localparam logic [BIN_W:0]    NyqBin = (BIN_W+1)'(FFT_POINTS / 2);
    localparam logic [SUM_W-1:0]  SumMax = {SUM_W{1'b1}};

    logic               st1_reg, st2_reg, go_reg;
    logic [BIN_W-1:0]   b1_reg, b2_reg;
    logic [MAG_W-1:0]   m1_reg, m2_reg;
    logic               e1_reg, e2_reg;
    logic [2*MAG_W-1:0] sq_reg;
    frame_t             frame_reg, frame_next;
    logic               in_nyq, in_low, in_ref;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                  input logic [2*MAG_W-1:0] q);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W+1-2*MAG_W){1'b0}}, q};
        return t[SUM_W] ? SumMax : t[SUM_W-1:0];
    endfunction

    assign busy     = st1_reg || st2_reg || go_reg;
    assign frame_go = go_reg;
    assign frame    = frame_reg;

    assign in_nyq = ({1'b0, b2_reg} <= NyqBin);
    assign in_low = in_nyq && (b2_reg >= cfg.edge_bin[0]) && (b2_reg <= cfg.edge_bin[4]);
    assign in_ref = in_nyq && (b2_reg >= cfg.edge_bin[0]) && (b2_reg <= cfg.ref_top);

    always_comb begin
        frame_next = frame_reg;
        if (frame_clear) begin
            frame_next = '0;
        end else if (st2_reg) begin
            for (int k = 0; k < 4; k++) begin
                if (in_nyq && b2_reg >= cfg.edge_bin[k] && b2_reg <= cfg.edge_bin[k+1]) begin
                    frame_next.band_sum[k] = sat_add(frame_reg.band_sum[k], sq_reg);
                end
            end
            if (in_low) begin
                frame_next.low_sum = sat_add(frame_reg.low_sum, sq_reg);
                if (m2_reg > frame_reg.peak_mag ||
                    (m2_reg != '0 && m2_reg == frame_reg.peak_mag &&
                     b2_reg < frame_reg.peak_bin)) begin
                    frame_next.peak_mag = m2_reg;
                    frame_next.peak_bin = b2_reg;
                end
            end
            if (in_ref) begin
                frame_next.ref_sum = sat_add(frame_reg.ref_sum, sq_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg   <= 1'b0;
            st2_reg   <= 1'b0;
            go_reg    <= 1'b0;
            frame_reg <= '0;
        end else begin
            st1_reg   <= in_take;
            st2_reg   <= st1_reg;
            go_reg    <= st2_reg && e2_reg;
            frame_reg <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            b1_reg <= in_bin;
            m1_reg <= (in_mag > MagMax) ? MagMax : in_mag;
            e1_reg <= in_end;
        end
        if (st1_reg) begin
            b2_reg <= b1_reg;
            m2_reg <= m1_reg;
            e2_reg <= e1_reg;
            sq_reg <= m1_reg * m1_reg;
        end
    end

endmodule
`default_nettype wire

// File: design/sbem_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbem_alu
// Shared multi-cycle unit: restoring divide (one quotient bit a cycle),
// integer square root (one root bit a cycle) and log2 in Q32 (normalise one
// bit a cycle, then one squaring round per fraction bit).
// ----------------------------------------------------------------------------
module sbem_alu (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sbem_pkg::alu_cmd_t cmd,
    output sbem_pkg::alu_sts_t      sts
);
    import sbem_pkg::*;

    localparam logic [1:0] LS_NORM = 2'd0;
    localparam logic [1:0] LS_MUL  = 2'd1;
    localparam logic [1:0] LS_FIX  = 2'd2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       ls_reg, ls_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [31:0]      root_reg, root_next;
    logic [31:0]      m_reg, m_next;
    logic [63:0]      prod_reg, prod_next;
    logic [4:0]       exp_reg, exp_next;
    logic [31:0]      frac_reg, frac_next;
    logic [DVS_W-1:0] res_reg, res_next;

    logic [DVS_W:0]   rem_sh;
    logic             div_ge;
    logic [35:0]      sq_r4, sq_trial;
    logic             sq_ge;
    logic [32:0]      lg_t;

    assign sts.done   = done_reg;
    assign sts.result = res_reg;

    assign rem_sh   = {rem_reg[DVS_W-1:0], num_reg[NUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, dvs_reg};
    assign sq_r4    = {rem_reg[33:0], num_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_r4 >= sq_trial;
    assign lg_t     = prod_reg[63:31];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        ls_next   = ls_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        root_next = root_reg;
        m_next    = m_reg;
        prod_next = prod_reg;
        exp_next  = exp_reg;
        frac_next = frac_reg;
        res_next  = res_reg;

        if (!busy_reg) begin
            if (cmd.start) begin
                op_next   = cmd.op;
                num_next  = cmd.a;
                dvs_next  = cmd.b;
                rem_next  = '0;
                root_next = '0;
                m_next    = cmd.a[31:0];
                exp_next  = 5'd31;
                frac_next = '0;
                ls_next   = LS_NORM;
                case (cmd.op)
                    OP_DIV: begin
                        cnt_next  = 7'(NUM_W);
                        busy_next = 1'b1;
                    end
                    OP_SQRT: begin
                        cnt_next  = 7'd32;
                        busy_next = 1'b1;
                    end
                    OP_LOG: begin
                        // log of zero is taken as zero
                        if (cmd.a[31:0] == 32'd0) begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end else begin
                            busy_next = 1'b1;
                        end
                    end
                    default: begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                endcase
            end
        end else begin
            case (op_reg)
                OP_DIV: begin
                    rem_next = div_ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
                    num_next = {num_reg[NUM_W-2:0], div_ge};
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = num_next[DVS_W-1:0];
                    end
                end
                OP_SQRT: begin
                    rem_next  = {{(DVS_W-35){1'b0}},
                                 (sq_ge ? (sq_r4 - sq_trial) : sq_r4)};
                    root_next = {root_reg[30:0], sq_ge};
                    num_next  = {num_reg[NUM_W-3:0], 2'b00};
                    cnt_next  = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = {32'd0, root_next};
                    end
                end
                OP_LOG: begin
                    case (ls_reg)
                        LS_NORM: begin
                            if (m_reg[31]) begin
                                ls_next  = LS_MUL;
                                cnt_next = 7'd32;
                            end else begin
                                m_next   = {m_reg[30:0], 1'b0};
                                exp_next = exp_reg - 5'd1;
                            end
                        end
                        LS_MUL: begin
                            prod_next = m_reg * m_reg;
                            ls_next   = LS_FIX;
                        end
                        LS_FIX: begin
                            // keep mantissa in [1,2): halve and emit a one on overflow
                            m_next    = lg_t[32] ? lg_t[32:1] : lg_t[31:0];
                            frac_next = {frac_reg[30:0], lg_t[32]};
                            cnt_next  = cnt_reg - 7'd1;
                            ls_next   = LS_MUL;
                            if (cnt_reg == 7'd1) begin
                                busy_next = 1'b0;
                                done_next = 1'b1;
                                res_next  = {27'd0, exp_reg, frac_next};
                            end
                        end
                        default: ls_next = LS_NORM;
                    endcase
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            ls_reg   <= LS_NORM;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            ls_reg   <= ls_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        root_reg <= root_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        exp_reg  <= exp_next;
        frac_reg <= frac_next;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire

// File: design/sbem_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbem_seq
// Frame-end sequencer: drives the shared unit to build the seven results and
// presents each one on the result channel.
// ----------------------------------------------------------------------------
module sbem_seq #(
    parameter int FFT_POINTS     = sbem_pkg::DEF_FFT_POINTS,
    parameter int SAMPLE_RATE_HZ = sbem_pkg::DEF_SAMPLE_RATE_HZ
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire sbem_pkg::cfg_t               cfg,
    input  wire sbem_pkg::frame_t             frame,
    input  wire logic                         frame_go,
    input  wire sbem_pkg::alu_sts_t           alu_sts,
    output sbem_pkg::alu_cmd_t                alu_cmd,
    output logic                              idle,
    output logic                              frame_clear,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [sbem_pkg::KIND_W-1:0]       m_result_kind,
    output logic [sbem_pkg::RAW_W-1:0]        m_raw_level,
    output logic [sbem_pkg::IDX_W-1:0]        m_index_tenths,
    output logic [sbem_pkg::BIN_W-1:0]        m_peak_bin,
    output logic [sbem_pkg::FREQ_W-1:0]       m_peak_freq_tenths_hz,
    output logic                              m_last_result
);
    import sbem_pkg::*;

    localparam logic [31:0] FreqScale = 32'(SAMPLE_RATE_HZ * 10);
    localparam logic [31:0] FreqHalf  = 32'(FFT_POINTS / 2);
    localparam int          FftShift  = $clog2(FFT_POINTS);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WAIT     = 4'd1;
    localparam logic [3:0] ST_LF_DONE  = 4'd2;
    localparam logic [3:0] ST_LC_DONE  = 4'd3;
    localparam logic [3:0] ST_RAW      = 4'd4;
    localparam logic [3:0] ST_BAND_Q   = 4'd5;
    localparam logic [3:0] ST_RAW_DONE = 4'd6;
    localparam logic [3:0] ST_IDX      = 4'd7;
    localparam logic [3:0] ST_LOG_Q    = 4'd8;
    localparam logic [3:0] ST_IDX_Q    = 4'd9;
    localparam logic [3:0] ST_SHARE_Q  = 4'd10;
    localparam logic [3:0] ST_FREQ     = 4'd11;
    localparam logic [3:0] ST_FREQ_Q   = 4'd12;
    localparam logic [3:0] ST_OUT      = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [3:0]        ret_reg, ret_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [LOG_W-1:0]  lf_reg, lf_next, lc_reg, lc_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BIN_W-1:0]  pbin_reg, pbin_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;

    logic [2:0]        hi_sel;
    logic [BIN_W-1:0]  e_lo, e_hi;
    logic [BIN_W:0]    band_cnt;
    logic [LOG_W-1:0]  res_log, num_l, den_l;
    logic [LOG_W+9:0]  scaled;
    logic [SUM_W+10:0] low_x2000;
    logic [DVS_W-1:0]  res;
    logic [DVS_W-1:0]  share_q;
    logic [BIN_W-1:0]  pbin_sel;
    logic [31:0]       freq_num;
    logic [31:0]       freq_sh;

    assign res      = alu_sts.result;
    assign res_log  = res[LOG_W-1:0];
    assign hi_sel   = (kind_reg < KIND_LOW) ? (kind_reg + 3'd1) : 3'd4;
    assign e_lo     = cfg.edge_bin[kind_reg[1:0]];
    assign e_hi     = cfg.edge_bin[hi_sel];
    assign band_cnt = {1'b0, e_hi} - {1'b0, e_lo} + {{BIN_W{1'b0}}, 1'b1};
    assign num_l    = (res_log > lf_reg) ? (res_log - lf_reg) : '0;
    assign den_l    = lc_reg - lf_reg;
    // x*1000 = x*1024 - x*16 - x*8, plus half the divisor to round
    assign scaled   = {num_l, 10'd0} - {6'd0, num_l, 4'd0} - {7'd0, num_l, 3'd0}
                      + {11'd0, den_l[LOG_W-1:1]};
    // x*2000 = x*2048 - x*32 - x*16
    assign low_x2000 = {frame.low_sum, 11'd0} - {6'd0, frame.low_sum, 5'd0}
                       - {7'd0, frame.low_sum, 4'd0};
    assign share_q  = (res + 64'd1) >> 1;
    assign pbin_sel = (frame.peak_mag == '0) ? cfg.edge_bin[0] : frame.peak_bin;
    assign freq_num = ({21'd0, pbin_reg} * FreqScale) + FreqHalf;
    // FFT length is a power of two: the rounding divide is a shift
    assign freq_sh  = freq_num >> FftShift;

    assign idle        = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign frame_clear = m_valid && m_ready && (kind_reg == KIND_PEAK);

    assign m_result_kind         = kind_reg;
    assign m_raw_level           = raw_reg;
    assign m_index_tenths        = idx_reg;
    assign m_peak_bin            = (kind_reg == KIND_PEAK) ? pbin_reg : '0;
    assign m_peak_freq_tenths_hz = freq_reg;
    assign m_last_result         = (kind_reg == KIND_PEAK);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        kind_next  = kind_reg;
        lf_next    = lf_reg;
        lc_next    = lc_reg;
        raw_next   = raw_reg;
        idx_next   = idx_reg;
        pbin_next  = pbin_reg;
        freq_next  = freq_reg;
        alu_cmd    = '{start: 1'b0, op: OP_DIV, a: '0, b: '0};

        case (state_reg)
            ST_IDLE: begin
                if (frame_go) begin
                    alu_cmd    = '{start: 1'b1, op: OP_LOG,
                                   a: {48'd0, cfg.idx_floor}, b: '0};
                    ret_next   = ST_LF_DONE;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (alu_sts.done) begin
                    state_next = ret_reg;
                end
            end
            ST_LF_DONE: begin
                lf_next    = res_log;
                alu_cmd    = '{start: 1'b1, op: OP_LOG,
                               a: {48'd0, cfg.idx_ceil}, b: '0};
                ret_next   = ST_LC_DONE;
                state_next = ST_WAIT;
            end
            ST_LC_DONE: begin
                lc_next    = res_log;
                kind_next  = KIND_BAND_ZERO;
                state_next = ST_RAW;
            end
            ST_RAW: begin
                if (kind_reg < KIND_LOW) begin
                    // reversed band edges give an empty band
                    if (e_hi >= e_lo) begin
                        alu_cmd    = '{start: 1'b1, op: OP_DIV,
                                       a: {13'd0, frame.band_sum[kind_reg[1:0]]},
                                       b: {52'd0, band_cnt}};
                        ret_next   = ST_BAND_Q;
                        state_next = ST_WAIT;
                    end else begin
                        raw_next   = '0;
                        state_next = ST_IDX;
                    end
                end else if (kind_reg == KIND_LOW) begin
                    alu_cmd    = '{start: 1'b1, op: OP_SQRT,
                                   a: {13'd0, frame.low_sum}, b: '0};
                    ret_next   = ST_RAW_DONE;
                    state_next = ST_WAIT;
                end else if (kind_reg == KIND_SHARE) begin
                    alu_cmd    = '{start: 1'b1, op: OP_SQRT,
                                   a: {13'd0, frame.ref_sum}, b: '0};
                    ret_next   = ST_RAW_DONE;
                    state_next = ST_WAIT;
                end else begin
                    raw_next   = {6'd0, frame.peak_mag};
                    state_next = ST_IDX;
                end
            end
            ST_BAND_Q: begin
                alu_cmd    = '{start: 1'b1, op: OP_SQRT, a: {8'd0, res}, b: '0};
                ret_next   = ST_RAW_DONE;
                state_next = ST_WAIT;
            end
            ST_RAW_DONE: begin
                raw_next   = res[RAW_W-1:0];
                state_next = ST_IDX;
            end
            ST_IDX: begin
                state_next = ST_FREQ;
                if (kind_reg == KIND_SHARE) begin
                    if (frame.ref_sum == '0) begin
                        idx_next = '0;
                    end else if (frame.low_sum >= frame.ref_sum) begin
                        idx_next = IDX_FULL;
                    end else begin
                        alu_cmd    = '{start: 1'b1, op: OP_DIV,
                                       a: {2'd0, low_x2000},
                                       b: {5'd0, frame.ref_sum}};
                        ret_next   = ST_SHARE_Q;
                        state_next = ST_WAIT;
                    end
                end else begin
                    if (raw_reg <= {6'd0, cfg.idx_floor}) begin
                        idx_next = '0;
                    end else if (raw_reg >= {6'd0, cfg.idx_ceil}) begin
                        idx_next = IDX_FULL;
                    end else if (lc_reg <= lf_reg) begin
                        idx_next = '0;
                    end else begin
                        alu_cmd    = '{start: 1'b1, op: OP_LOG,
                                       a: {42'd0, raw_reg}, b: '0};
                        ret_next   = ST_LOG_Q;
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_LOG_Q: begin
                alu_cmd    = '{start: 1'b1, op: OP_DIV,
                               a: {25'd0, scaled}, b: {27'd0, den_l}};
                ret_next   = ST_IDX_Q;
                state_next = ST_WAIT;
            end
            ST_IDX_Q: begin
                idx_next   = (res > {54'd0, IDX_FULL}) ? IDX_FULL : res[IDX_W-1:0];
                state_next = ST_FREQ;
            end
            ST_SHARE_Q: begin
                idx_next   = (share_q > {54'd0, IDX_FULL}) ? IDX_FULL
                                                           : share_q[IDX_W-1:0];
                state_next = ST_FREQ;
            end
            ST_FREQ: begin
                pbin_next = pbin_sel;
                if (kind_reg == KIND_PEAK) begin
                    state_next = ST_FREQ_Q;
                end else begin
                    freq_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_FREQ_Q: begin
                // pbin_reg now settled: scale, round and saturate the frequency
                freq_next  = (freq_sh > {16'd0, FREQ_MAX}) ? FREQ_MAX
                                                          : freq_sh[FREQ_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (kind_reg == KIND_PEAK) begin
                        state_next = ST_IDLE;
                    end else begin
                        kind_next  = kind_reg + 3'd1;
                        state_next = ST_RAW;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            kind_reg  <= KIND_BAND_ZERO;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge aclk) begin
        lf_reg   <= lf_next;
        lc_reg   <= lc_next;
        raw_reg  <= raw_next;
        idx_reg  <= idx_next;
        pbin_reg <= pbin_next;
        freq_reg <= freq_next;
    end

endmodule
`default_nettype wire

// File: design/spectral_band_energy_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Bin path: each bin beat is captured, squared, then accumulated; s_ready is low meanwhile.
// Bins: a new bin is taken only after the previous one has been added by the square-then-add path in sbem_accum.
// Frame end: the seven result beats are worked out one operation at a time on the shared
//   divide/root/log unit, and each beat waits for the result channel to take it.
// Reset: synchronous, active low; clears sums, peak and sequencer, loads register defaults.
// ----------------------------------------------------------------------------
// spectral_band_energy_meter_core
// FFT bin power meter: four band levels, low total, low share of reference
// power and dominant low-band peak, each with a 0..1000 index (log, linear for the share).
// ----------------------------------------------------------------------------
module spectral_band_energy_meter_core #(
    parameter int FFT_POINTS     = sbem_pkg::DEF_FFT_POINTS,
    parameter int SAMPLE_RATE_HZ = sbem_pkg::DEF_SAMPLE_RATE_HZ,
    parameter int MAG_BITS       = sbem_pkg::DEF_MAG_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sbem_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // bin channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sbem_pkg::BIN_W-1:0]    s_bin_number,
    input  wire logic [sbem_pkg::MAG_W-1:0]    s_magnitude,
    input  wire logic                          s_frame_end,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sbem_pkg::KIND_W-1:0]        m_result_kind,
    output logic [sbem_pkg::RAW_W-1:0]         m_raw_level,
    output logic [sbem_pkg::IDX_W-1:0]         m_index_tenths,
    output logic [sbem_pkg::BIN_W-1:0]         m_peak_bin,
    output logic [sbem_pkg::FREQ_W-1:0]        m_peak_freq_tenths_hz,
    output logic                               m_last_result
);
    import sbem_pkg::*;

    cfg_t     cfg;
    frame_t   frame;
    alu_cmd_t alu_cmd;
    alu_sts_t alu_sts;
    logic     acc_busy, frame_go, frame_clear, seq_idle, in_take;

    // Zero-wait-state register port.
    assign pready = 1'b1;

    // Take a bin only when the front end is empty and no frame is being finished.
    assign s_ready = seq_idle && !acc_busy;
    assign in_take = s_valid && s_ready;

    sbem_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Square and accumulate; raise frame_go once the frame's last bin is in.
    sbem_accum #(
        .FFT_POINTS (FFT_POINTS),
        .MAG_BITS   (MAG_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_take     (in_take),
        .in_bin      (s_bin_number),
        .in_mag      (s_magnitude),
        .in_end      (s_frame_end),
        .frame_clear (frame_clear),
        .busy        (acc_busy),
        .frame_go    (frame_go),
        .frame       (frame)
    );

    // One shared divide / square-root / log2 unit for all finishing divides, roots and logs.
    sbem_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .sts     (alu_sts)
    );

    // Walk the seven results; hold each beat until taken, then drop the frame sums
    // as the peak beat leaves.
    sbem_seq #(
        .FFT_POINTS     (FFT_POINTS),
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_seq (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg),
        .frame                 (frame),
        .frame_go              (frame_go),
        .alu_sts               (alu_sts),
        .alu_cmd               (alu_cmd),
        .idle                  (seq_idle),
        .frame_clear           (frame_clear),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_result_kind         (m_result_kind),
        .m_raw_level           (m_raw_level),
        .m_index_tenths        (m_index_tenths),
        .m_peak_bin            (m_peak_bin),
        .m_peak_freq_tenths_hz (m_peak_freq_tenths_hz),
        .m_last_result         (m_last_result)
    );

endmodule
`default_nettype wire
